/* hdl/ppe_pkg.sv */
// package: payload types, item kinds, register addresses and sequencer states
`timescale 1ns / 1ps
`default_nettype none

package ppe_pkg;

  localparam int PIECE_W = 4;
  localparam int WORD_W  = 32;

  // item kinds
  localparam logic [1:0] KIND_EVAL      = 2'd0;
  localparam logic [1:0] KIND_LOAD_BP   = 2'd1;
  localparam logic [1:0] KIND_LOAD_COEF = 2'd2;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_NUM_PIECES  = 2'd0;
  localparam logic [1:0] REG_POLY_DEGREE = 2'd1;
  localparam logic [1:0] REG_COEFF_LAYOUT = 2'd2;

  typedef struct packed {
    logic [1:0]               kind;
    logic [6:0]               table_index;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] y;
    logic [PIECE_W-1:0]       piece;
  } out_item_t;

  typedef enum logic [2:0] {
    STATE_IDLE,
    STATE_SEARCH,
    STATE_COEF0,
    STATE_MUL,
    STATE_ADD,
    STATE_DONE
  } state_e;

endpackage

`default_nettype wire

/* hdl/ppe_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module ppe_ram #(
  parameter int  Width = 32,
  parameter int  Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/piecewise_polynomial_eval.sv */
// top level: piecewise polynomial evaluator, signed q16.16, sequenced horner unit
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel (in_valid_i / in_stall_o / in_item_i) takes load and evaluate items;
//   a transfer happens on a rising edge with valid high and stall low
//   load items write the breakpoint or coefficient ram in the transfer cycle and
//   produce nothing; the block can take one load per cycle while idle
//   an evaluate item starts the sequencer: a linear breakpoint search, one ram
//   read per cycle until the selected piece is found, a step to fetch the
//   leading coefficient, then d horner steps, each a multiply step and then a
//   shift, add and saturate step, on the single shared 32x32 multiplier
//   the result is registered as the sequencer leaves its done step, and the
//   next item is taken only once the sequencer is back in idle (d = poly degree)
//   in_stall_o is high for the whole evaluation
//   the output register holds the result until taken; if the receiver stalls,
//   a finished evaluation waits in the last step and new items are refused
//   reset clears the sequencer, output valid and config registers (1, 3, 0); the
//   tables are undefined until loaded; config is written through the apb-style port,
//   by the user only while the block is idle, which the block does not enforce

module piecewise_polynomial_eval #(
  parameter int MAX_PIECES = 16,
  parameter int MAX_DEGREE = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire ppe_pkg::in_item_t in_item_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output ppe_pkg::out_item_t    out_item_o,
  // config port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  // table geometry
  localparam int BpDepth = MAX_PIECES + 1;
  localparam int BpAw    = $clog2(BpDepth);
  localparam int CoDepth = MAX_PIECES * (MAX_DEGREE + 1);
  localparam int CoAw    = (CoDepth > 1) ? $clog2(CoDepth) : 1;
  localparam int NpW     = $clog2(MAX_PIECES + 1);
  localparam int KW      = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int DegW    = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam int WW      = ppe_pkg::WORD_W;

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  logic [4:0] num_pieces_q;
  logic [2:0] poly_degree_q;
  logic       coeff_layout_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_pieces_q   <= 5'd1;
      poly_degree_q  <= 3'd3;
      coeff_layout_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        ppe_pkg::REG_NUM_PIECES:   num_pieces_q   <= pwdata[4:0];
        ppe_pkg::REG_POLY_DEGREE:  poly_degree_q  <= pwdata[2:0];
        ppe_pkg::REG_COEFF_LAYOUT: coeff_layout_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      ppe_pkg::REG_NUM_PIECES:   prdata = {27'd0, num_pieces_q};
      ppe_pkg::REG_POLY_DEGREE:  prdata = {29'd0, poly_degree_q};
      ppe_pkg::REG_COEFF_LAYOUT: prdata = {31'd0, coeff_layout_q};
      default:                   prdata = 32'd0;
    endcase
  end

  // effective piece count and degree, clamped to what the tables hold
  logic [NpW-1:0]  np_eff;
  logic [DegW-1:0] deg_eff;

  always_comb begin
    if (num_pieces_q == 5'd0) begin
      np_eff = NpW'(1);
    end else if (int'(num_pieces_q) > MAX_PIECES) begin
      np_eff = NpW'(MAX_PIECES);
    end else begin
      np_eff = NpW'(num_pieces_q);
    end
    if (int'(poly_degree_q) > MAX_DEGREE) begin
      deg_eff = DegW'(MAX_DEGREE);
    end else begin
      deg_eff = DegW'(poly_degree_q);
    end
  end

  // ---------------------------------------------------------------------------
  // tables
  // ---------------------------------------------------------------------------
  logic            bp_we, bp_re;
  logic [BpAw-1:0] bp_raddr;
  logic [WW-1:0]   bp_rdata;
  logic            co_we, co_re;
  logic [CoAw-1:0] co_raddr;
  logic [WW-1:0]   co_rdata;

  ppe_ram #(
    .Width (WW),
    .Depth (BpDepth)
  ) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (bp_we),
    .waddr_i (BpAw'(in_item_i.table_index)),
    .wdata_i (in_item_i.value),
    .re_i    (bp_re),
    .raddr_i (bp_raddr),
    .rdata_o (bp_rdata)
  );

  ppe_ram #(
    .Width (WW),
    .Depth (CoDepth)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (co_we),
    .waddr_i (CoAw'(in_item_i.table_index)),
    .wdata_i (in_item_i.value),
    .re_i    (co_re),
    .raddr_i (co_raddr),
    .rdata_o (co_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer and datapath
  // ---------------------------------------------------------------------------
  ppe_pkg::state_e    state_q, state_d;
  logic signed [WW-1:0]   x_q, x_d;
  logic [NpW-1:0]     np_q, np_d;
  logic [DegW-1:0]    deg_q, deg_d;
  logic               layout_q, layout_d;
  logic [KW-1:0]      k_q, k_d;         // piece under test, then selected piece
  logic [CoAw-1:0]    base_q, base_d;   // k * (deg + 1), start for contiguous layout
  logic [CoAw-1:0]    ca_q, ca_d;       // next coefficient address
  logic [DegW-1:0]    cnt_q, cnt_d;     // horner steps still to run
  logic signed [WW-1:0]   acc_q, acc_d;
  logic signed [2*WW-1:0] prod_q, prod_d;
  logic               out_valid_q, out_valid_d;
  ppe_pkg::out_item_t out_item_q, out_item_d;

  logic               in_xfer, out_free;
  logic [CoAw-1:0]    stride, start;
  logic signed [WW+16:0]  sum;
  logic signed [WW-1:0]   sat_sum;

  assign in_stall_o  = (state_q != ppe_pkg::STATE_IDLE);
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // coefficient walk: stride one per piece, or num_pieces when interleaved
  assign stride = layout_q ? CoAw'(np_q) : CoAw'(1);
  assign start  = layout_q ? CoAw'(k_q) : base_q;

  // horner step: floor shift of the product, add coefficient, saturate
  assign sum = (WW+17)'($signed(prod_q[2*WW-1:16])) + (WW+17)'($signed(co_rdata));

  always_comb begin
    if (sum[WW+16:WW-1] == {18{1'b0}} || sum[WW+16:WW-1] == {18{1'b1}}) begin
      sat_sum = sum[WW-1:0];
    end else if (sum[WW+16]) begin
      sat_sum = {1'b1, {(WW-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(WW-1){1'b1}}};
    end
  end

  always_comb begin
    logic found;
    found       = (x_q < $signed(bp_rdata)) || (NpW'(k_q) == np_q - NpW'(1));

    state_d     = state_q;
    x_d         = x_q;
    np_d        = np_q;
    deg_d       = deg_q;
    layout_d    = layout_q;
    k_d         = k_q;
    base_d      = base_q;
    ca_d        = ca_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_item_d  = out_item_q;

    bp_we    = 1'b0;
    bp_re    = 1'b0;
    bp_raddr = BpAw'(1);
    co_we    = 1'b0;
    co_re    = 1'b0;
    co_raddr = ca_q;

    unique case (state_q)
      ppe_pkg::STATE_IDLE: begin
        if (in_xfer) begin
          priority if (in_item_i.kind == ppe_pkg::KIND_EVAL) begin
            x_d      = in_item_i.value;
            np_d     = np_eff;
            deg_d    = deg_eff;
            layout_d = coeff_layout_q;
            k_d      = '0;
            base_d   = '0;
            bp_re    = 1'b1;
            bp_raddr = BpAw'(1);
            state_d  = ppe_pkg::STATE_SEARCH;
          end else if (in_item_i.kind == ppe_pkg::KIND_LOAD_BP) begin
            bp_we = (32'(in_item_i.table_index) < 32'(BpDepth));
          end else if (in_item_i.kind == ppe_pkg::KIND_LOAD_COEF) begin
            co_we = (32'(in_item_i.table_index) < 32'(CoDepth));
          end else begin
            // unused kind: dropped
          end
        end
      end

      ppe_pkg::STATE_SEARCH: begin
        if (found) begin
          co_re    = 1'b1;
          co_raddr = start;
          ca_d     = start + stride;
          state_d  = ppe_pkg::STATE_COEF0;
        end else begin
          k_d      = k_q + KW'(1);
          base_d   = base_q + CoAw'(deg_q) + CoAw'(1);
          bp_re    = 1'b1;
          bp_raddr = BpAw'(k_q) + BpAw'(2);
        end
      end

      ppe_pkg::STATE_COEF0: begin
        acc_d = $signed(co_rdata);
        if (deg_q == '0) begin
          state_d = ppe_pkg::STATE_DONE;
        end else begin
          cnt_d    = deg_q;
          co_re    = 1'b1;
          co_raddr = ca_q;
          ca_d     = ca_q + stride;
          state_d  = ppe_pkg::STATE_MUL;
        end
      end

      ppe_pkg::STATE_MUL: begin
        prod_d  = acc_q * x_q;
        state_d = ppe_pkg::STATE_ADD;
      end

      ppe_pkg::STATE_ADD: begin
        acc_d = sat_sum;
        if (cnt_q == DegW'(1)) begin
          state_d = ppe_pkg::STATE_DONE;
        end else begin
          cnt_d    = cnt_q - DegW'(1);
          co_re    = 1'b1;
          co_raddr = ca_q;
          ca_d     = ca_q + stride;
          state_d  = ppe_pkg::STATE_MUL;
        end
      end

      ppe_pkg::STATE_DONE: begin
        // wait here while the output register is still full
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_item_d.y     = acc_q;
          out_item_d.piece = ppe_pkg::PIECE_W'(k_q);
          state_d          = ppe_pkg::STATE_IDLE;
        end
      end

      default: state_d = ppe_pkg::STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppe_pkg::STATE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    np_q       <= np_d;
    deg_q      <= deg_d;
    layout_q   <= layout_d;
    k_q        <= k_d;
    base_q     <= base_d;
    ca_q       <= ca_d;
    cnt_q      <= cnt_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    out_item_q <= out_item_d;
  end

endmodule

`default_nettype wire

/* hdl/ppe_checker.sv */
// checker on the top-level ports, bound to the evaluator
`timescale 1ns / 1ps
`default_nettype none

module ppe_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire ppe_pkg::in_item_t  in_item_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire ppe_pkg::out_item_t out_item_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // an evaluate transfer makes the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.kind == ppe_pkg::KIND_EVAL |=> in_stall_o)
    else $error("evaluate transfer did not start the sequencer");

  // a load on an idle block produces no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o &&
    (in_item_i.kind == ppe_pkg::KIND_LOAD_BP || in_item_i.kind == ppe_pkg::KIND_LOAD_COEF)
    |=> !out_valid_o)
    else $error("load produced a result");

  // a new result only appears at the end of an evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

endmodule

bind piecewise_polynomial_eval ppe_checker u_ppe_checker (.*);

`default_nettype wire
